// ===== src/mmn_pkg.sv =====
`timescale 1ns / 1ps

package mmn_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_MIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MAX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MAX_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_CAL_EN   = 3'd6;

  localparam logic signed [15:0] SEED_MIN_RESET = 16'sh8000;
  localparam logic signed [15:0] SEED_MAX_RESET = 16'sh7FFF;
  localparam logic signed [15:0] NORM_POS_SAT   = 16'sh7FFF;
  localparam logic signed [15:0] NORM_NEG_SAT   = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } mmn_in_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               window_updated;
    logic               range_error;
  } mmn_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIDEN,
    S_SPAN,
    S_ABS,
    S_CHK,
    S_DIV,
    S_FIN,
    S_OUT
  } mmn_state_t;

endpackage

// ===== src/mmn_stream_if.sv =====
`timescale 1ns / 1ps

interface mmn_in_if;
  logic            valid;
  logic            ready;
  mmn_pkg::mmn_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmn_out_if;
  logic             valid;
  logic             ready;
  mmn_pkg::mmn_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mag_minmax_window_normalizer_core.sv =====
`timescale 1ns / 1ps
// Each sample's three axes go one after another through the shared 17-step restoring divider;
// an axis with zero span or a saturating quotient skips the divider. ready is high only while
// idle, so a new sample is taken only after the last result is loaded into the output register.
// Reset (rst_n low, synchronous): window min/max to -32768/32767, calibration on,
// sequencer idle, result channel empty.
module mag_minmax_window_normalizer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mmn_in_if.sink                               in_chan,
  mmn_out_if.source                            out_chan,
  input  logic                                 cfg_we,
  input  logic [mmn_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [mmn_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mmn_pkg::mmn_state_t state_r, state_nxt;

  logic signed [15:0] win_min_r [mmn_pkg::AXES];
  logic signed [15:0] win_min_nxt [mmn_pkg::AXES];
  logic signed [15:0] win_max_r [mmn_pkg::AXES];
  logic signed [15:0] win_max_nxt [mmn_pkg::AXES];
  logic               cal_en_r, cal_en_nxt;

  logic signed [15:0] raw_r [mmn_pkg::AXES];
  logic signed [15:0] raw_nxt [mmn_pkg::AXES];
  logic signed [15:0] res_r [mmn_pkg::AXES];
  logic signed [15:0] res_nxt [mmn_pkg::AXES];

  logic [1:0]         axis_r, axis_nxt;
  logic               upd_r, upd_nxt;
  logic               err_r, err_nxt;
  logic signed [16:0] span_r, span_nxt;
  logic signed [18:0] num_r, num_nxt;
  logic               neg_r, neg_nxt;
  logic [17:0]        an_r, an_nxt;
  logic [15:0]        as_r, as_nxt;
  logic               zero_r, zero_nxt;
  logic               sat_r, sat_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [16:0]        dvd_r, dvd_nxt;
  logic [16:0]        quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  mmn_pkg::mmn_out_t  out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [15:0] cur_raw, cur_min, cur_max;
  logic signed [16:0] diff_c;
  logic [16:0]        trial_c;
  logic [17:0]        qsum_c;
  logic [16:0]        qr_c;
  logic signed [15:0] val_c;
  logic               in_fire;
  logic               out_load;

  assign in_chan.ready  = (state_r == mmn_pkg::S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;
  assign out_load       = (state_r == mmn_pkg::S_OUT) && (!out_valid_r || out_chan.ready);

  assign cur_raw = raw_r[axis_r];
  assign cur_min = win_min_r[axis_r];
  assign cur_max = win_max_r[axis_r];
  assign diff_c  = {cur_raw[15], cur_raw} - {cur_min[15], cur_min};
  assign trial_c = {rem_r, dvd_r[16]};
  assign qsum_c  = {1'b0, quo_r} + 18'd1;
  assign qr_c    = qsum_c[17:1];

  always_comb begin
    if (zero_r) begin
      val_c = 16'sd0;
    end else if (neg_r) begin
      if (sat_r || qr_c >= 17'd32768) begin
        val_c = mmn_pkg::NORM_NEG_SAT;
      end else begin
        val_c = 16'(17'd0 - qr_c);
      end
    end else begin
      if (sat_r || qr_c >= 17'd32767) begin
        val_c = mmn_pkg::NORM_POS_SAT;
      end else begin
        val_c = qr_c[15:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmn_pkg::S_IDLE:  if (in_fire) state_nxt = mmn_pkg::S_WIDEN;
      mmn_pkg::S_WIDEN: state_nxt = mmn_pkg::S_SPAN;
      mmn_pkg::S_SPAN:  state_nxt = mmn_pkg::S_ABS;
      mmn_pkg::S_ABS:   state_nxt = mmn_pkg::S_CHK;
      mmn_pkg::S_CHK: begin
        if (as_r == 16'd0 || an_r >= {as_r, 2'b00}) begin
          state_nxt = mmn_pkg::S_FIN;
        end else begin
          state_nxt = mmn_pkg::S_DIV;
        end
      end
      mmn_pkg::S_DIV: begin
        if (cnt_r == 5'(mmn_pkg::DIV_STEPS - 1)) state_nxt = mmn_pkg::S_FIN;
      end
      mmn_pkg::S_FIN: begin
        if (axis_r == 2'(mmn_pkg::AXES - 1)) begin
          state_nxt = mmn_pkg::S_OUT;
        end else begin
          state_nxt = mmn_pkg::S_WIDEN;
        end
      end
      mmn_pkg::S_OUT:   if (out_load) state_nxt = mmn_pkg::S_IDLE;
      default:          state_nxt = mmn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    win_min_nxt   = win_min_r;
    win_max_nxt   = win_max_r;
    cal_en_nxt    = cal_en_r;
    raw_nxt       = raw_r;
    res_nxt       = res_r;
    axis_nxt      = axis_r;
    upd_nxt       = upd_r;
    err_nxt       = err_r;
    span_nxt      = span_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    an_nxt        = an_r;
    as_nxt        = as_r;
    zero_nxt      = zero_r;
    sat_nxt       = sat_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      if (cfg_idx inside {[mmn_pkg::REG_SEED_MIN_X:mmn_pkg::REG_SEED_MIN_Z]}) begin
        win_min_nxt[cfg_idx[1:0]] = cfg_data[15:0];
      end else if (cfg_idx inside {[mmn_pkg::REG_SEED_MAX_X:mmn_pkg::REG_SEED_MAX_Z]}) begin
        win_max_nxt[2'(cfg_idx - mmn_pkg::REG_SEED_MAX_X)] = cfg_data[15:0];
      end else if (cfg_idx == mmn_pkg::REG_CONT_CAL_EN) begin
        cal_en_nxt = cfg_data[0];
      end
    end

    case (state_r)
      mmn_pkg::S_IDLE: begin
        if (in_fire) begin
          raw_nxt[0] = in_chan.data.mag_x;
          raw_nxt[1] = in_chan.data.mag_y;
          raw_nxt[2] = in_chan.data.mag_z;
          axis_nxt   = 2'd0;
          upd_nxt    = 1'b0;
          err_nxt    = 1'b0;
        end
      end
      mmn_pkg::S_WIDEN: begin
        if (cal_en_r) begin
          if (cur_raw > cur_max) begin
            win_max_nxt[axis_r] = cur_raw;
            upd_nxt             = 1'b1;
          end
          if (cur_raw < cur_min) begin
            win_min_nxt[axis_r] = cur_raw;
            upd_nxt             = 1'b1;
          end
        end
      end
      mmn_pkg::S_SPAN: begin
        span_nxt = {cur_max[15], cur_max} - {cur_min[15], cur_min};
        num_nxt  = {diff_c[16], diff_c, 1'b0} - {{2{span_nxt[16]}}, span_nxt};
      end
      mmn_pkg::S_ABS: begin
        neg_nxt = num_r[18] ^ span_r[16];
        an_nxt  = num_r[18] ? 18'(-num_r) : num_r[17:0];
        as_nxt  = span_r[16] ? 16'(-span_r) : span_r[15:0];
      end
      mmn_pkg::S_CHK: begin
        zero_nxt = (as_r == 16'd0);
        sat_nxt  = (an_r >= {as_r, 2'b00});
        rem_nxt  = an_r[17:2];
        dvd_nxt  = {an_r[1:0], 15'd0};
        quo_nxt  = 17'd0;
        cnt_nxt  = 5'd0;
      end
      mmn_pkg::S_DIV: begin
        if (trial_c >= {1'b0, as_r}) begin
          rem_nxt = 16'(trial_c - {1'b0, as_r});
          quo_nxt = {quo_r[15:0], 1'b1};
        end else begin
          rem_nxt = trial_c[15:0];
          quo_nxt = {quo_r[15:0], 1'b0};
        end
        dvd_nxt = {dvd_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
      end
      mmn_pkg::S_FIN: begin
        res_nxt[axis_r] = val_c;
        err_nxt         = err_r | zero_r;
        if (axis_r != 2'(mmn_pkg::AXES - 1)) axis_nxt = axis_r + 2'd1;
      end
      mmn_pkg::S_OUT: begin
        if (out_load) begin
          out_nxt.norm_x         = res_r[0];
          out_nxt.norm_y         = res_r[1];
          out_nxt.norm_z         = res_r[2];
          out_nxt.window_updated = upd_r;
          out_nxt.range_error    = err_r;
          out_valid_nxt          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmn_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cal_en_r    <= 1'b1;
      for (int i = 0; i < mmn_pkg::AXES; i++) begin
        win_min_r[i] <= mmn_pkg::SEED_MIN_RESET;
        win_max_r[i] <= mmn_pkg::SEED_MAX_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cal_en_r    <= cal_en_nxt;
      win_min_r   <= win_min_nxt;
      win_max_r   <= win_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r  <= raw_nxt;
    res_r  <= res_nxt;
    axis_r <= axis_nxt;
    upd_r  <= upd_nxt;
    err_r  <= err_nxt;
    span_r <= span_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    an_r   <= an_nxt;
    as_r   <= as_nxt;
    zero_r <= zero_nxt;
    sat_r  <= sat_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== sim/mmn_window_checker.sv =====
`timescale 1ns / 1ps

module mmn_window_checker
  import mmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mmn_in_if                     in_mon,
  mmn_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  int       win_lo [AXES];
  int       win_hi [AXES];
  logic     cal_on;
  mmn_out_t results_due [$];

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic signed [15:0] scale_axis(int raw, int lo, int hi);
    longint span;
    longint num;
    longint mag_n;
    longint mag_s;
    longint q;
    logic   neg;
    span  = longint'(hi) - longint'(lo);
    num   = 2 * (longint'(raw) - longint'(lo)) - span;
    neg   = (num < 0) != (span < 0);
    mag_n = (num < 0) ? -num : num;
    mag_s = (span < 0) ? -span : span;
    q     = (mag_n * 32768 + mag_s) / (2 * mag_s);
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic mmn_out_t predict_sample(mmn_in_t s);
    int                 raw  [AXES];
    logic signed [15:0] norm [AXES];
    mmn_out_t           r;
    raw[0] = s.mag_x;
    raw[1] = s.mag_y;
    raw[2] = s.mag_z;
    r = '0;
    if (cal_on) begin
      for (int a = 0; a < AXES; a++) begin
        if (raw[a] > win_hi[a]) begin
          win_hi[a] = raw[a];
          r.window_updated = 1'b1;
        end
        if (raw[a] < win_lo[a]) begin
          win_lo[a] = raw[a];
          r.window_updated = 1'b1;
        end
      end
    end
    for (int a = 0; a < AXES; a++) begin
      if (win_hi[a] == win_lo[a]) begin
        r.range_error = 1'b1;
        norm[a] = '0;
      end else begin
        norm[a] = scale_axis(raw[a], win_lo[a], win_hi[a]);
      end
    end
    r.norm_x = norm[0];
    r.norm_y = norm[1];
    r.norm_z = norm[2];
    return r;
  endfunction

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    if (idx <= REG_SEED_MIN_Z) begin
      win_lo[idx - REG_SEED_MIN_X] = int'($signed(value));
    end else if (idx >= REG_SEED_MAX_X && idx <= REG_SEED_MAX_Z) begin
      win_hi[idx - REG_SEED_MAX_X] = int'($signed(value));
    end else if (idx == REG_CONT_CAL_EN) begin
      cal_on = value[0];
    end
  endtask

  task automatic check_result(mmn_out_t got, mmn_out_t want);
    if (got.norm_x !== want.norm_x)
      report($sformatf("norm_x got %0d want %0d", got.norm_x, want.norm_x));
    if (got.norm_y !== want.norm_y)
      report($sformatf("norm_y got %0d want %0d", got.norm_y, want.norm_y));
    if (got.norm_z !== want.norm_z)
      report($sformatf("norm_z got %0d want %0d", got.norm_z, want.norm_z));
    if (got.window_updated !== want.window_updated)
      report($sformatf("window_updated got %b want %b",
                       got.window_updated, want.window_updated));
    if (got.range_error !== want.range_error)
      report($sformatf("range_error got %b want %b", got.range_error, want.range_error));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        win_lo[a] = int'(SEED_MIN_RESET);
        win_hi[a] = int'(SEED_MAX_RESET);
      end
      cal_on = 1'b1;
      results_due.delete();
    end else begin
      if (cfg_we) apply_write(cfg_idx, cfg_data);
      if (in_mon.valid && in_mon.ready) results_due.push_back(predict_sample(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) report("result transaction with none expected");
        else check_result(out_mon.data, results_due.pop_front());
      end
    end
    outstanding <= results_due.size();
  end

endmodule

// ===== sim/mag_minmax_window_normalizer_core_test.sv =====
`timescale 1ns / 1ps

module mag_minmax_window_normalizer_core_test;
  import mmn_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int PHASE_ITEMS    = 115;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_CONT_CAL_EN + 3'd1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    burst_left;
  logic [15:0]           seed_lo [AXES];
  logic [15:0]           seed_hi [AXES];
  int                    ctr [AXES];
  int                    amp [AXES];

  mmn_in_if  in_chan ();
  mmn_out_if out_chan ();

  mag_minmax_window_normalizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  mmn_window_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic cal);
    for (int a = 0; a < AXES; a++) write_reg(CFG_IDX_W'(REG_SEED_MIN_X + a), seed_lo[a]);
    for (int a = 0; a < AXES; a++) write_reg(CFG_IDX_W'(REG_SEED_MAX_X + a), seed_hi[a]);
    write_reg(REG_CONT_CAL_EN, {15'($urandom), cal});
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic set_seeds(int lx, int ly, int lz, int hx, int hy, int hz, logic cal);
    seed_lo[0] = 16'(lx);
    seed_lo[1] = 16'(ly);
    seed_lo[2] = 16'(lz);
    seed_hi[0] = 16'(hx);
    seed_hi[1] = 16'(hy);
    seed_hi[2] = 16'(hz);
    apply_setting(cal);
  endtask

  task automatic offer_xyz(int x, int y, int z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 90));
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : int'($urandom_range(1, 12));
    end
    in_chan.valid      <= 1'b1;
    in_chan.data.mag_x <= 16'(x);
    in_chan.data.mag_y <= 16'(y);
    in_chan.data.mag_z <= 16'(z);
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    burst_left--;
  endtask

  // hold until every result is back and the sequencer is idle
  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_raw(int c, int a);
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return int'($urandom_range(0, 65535)) - 32768;
    if (pick < 10) return (pick == 8) ? -32768 : 32767;
    v = c + int'($urandom_range(0, 2 * a)) - a;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic pick_window(int k, output logic cal);
    for (int a = 0; a < AXES; a++) begin
      ctr[a] = int'($urandom_range(0, 8000)) - 4000;
      amp[a] = $urandom_range(20, 3000);
      case (k)
        0: begin
          seed_lo[a] = SEED_MIN_RESET;
          seed_hi[a] = SEED_MAX_RESET;
        end
        1: begin
          seed_lo[a] = 16'(ctr[a] - int'($urandom_range(0, 40)));
          seed_hi[a] = 16'(ctr[a] + int'($urandom_range(0, 40)));
        end
        2: begin
          seed_lo[a] = 16'(ctr[a] + int'($urandom_range(0, 2 * amp[a])) - amp[a]);
          seed_hi[a] = 16'(ctr[a] + int'($urandom_range(0, 2 * amp[a])) - amp[a]);
          if (a == 0 && $urandom_range(0, 1) == 1) seed_hi[a] = seed_lo[a];
        end
        3: begin
          seed_lo[a] = 16'($urandom);
          seed_hi[a] = 16'($urandom);
        end
        4: begin
          seed_lo[a] = SEED_MAX_RESET;
          seed_hi[a] = SEED_MIN_RESET;
        end
        default: begin
          seed_lo[a] = 16'(ctr[a]);
          seed_hi[a] = 16'(ctr[a]);
        end
      endcase
    end
    case (k)
      2:       cal = 1'b0;
      3:       cal = 1'($urandom_range(0, 1));
      default: cal = 1'b1;
    endcase
  endtask

  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_chan.ready <= 1'b1;
    repeat (3000) @(posedge clk);
    // long hold-off so the block fills up and backs up the input
    out_chan.ready <= 1'b0;
    repeat (400) @(posedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_chan.ready <= 1'b0;
          repeat ($urandom_range(100, 300)) @(posedge clk);
        end
        1, 2, 3, 4: begin
          out_chan.ready <= 1'b1;
          repeat ($urandom_range(50, 400)) @(posedge clk);
        end
        default: begin
          repeat ($urandom_range(20, 200)) begin
            out_chan.ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  initial begin
    logic cal_bit;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_xyz(-32768, 32767, 0);
    offer_xyz(32767, -32768, -1);
    offer_xyz(0, 1, -1);
    offer_xyz(16384, -16384, 12345);
    settle();

    // equal x window, inverted z window, calibration off
    set_seeds(100, 0, 500, 100, 1000, -500, 1'b0);
    offer_xyz(100, 500, 0);
    offer_xyz(-32768, 32767, 600);
    offer_xyz(200, 1000, -500);
    offer_xyz(101, -1, 499);
    settle();

    // calibration on with collapsed and inverted windows
    set_seeds(5, 10, 500, 5, 10, -500, 1'b1);
    offer_xyz(5, 10, 0);
    offer_xyz(6, 9, 1000);
    offer_xyz(-32768, 32767, -32768);
    offer_xyz(32767, -32768, 32767);
    settle();

    // narrow window to drive saturation
    set_seeds(-1, -1, -1, 1, 1, 1, 1'b0);
    offer_xyz(32767, -32768, 0);
    offer_xyz(2, -2, 1);
    offer_xyz(-1, 1, 0);
    offer_xyz(1, -1, -1);
    settle();

    for (int k = 0; k < 6; k++) begin
      pick_window(k, cal_bit);
      apply_setting(cal_bit);
      repeat (PHASE_ITEMS)
        offer_xyz(pick_raw(ctr[0], amp[0]), pick_raw(ctr[1], amp[1]),
                  pick_raw(ctr[2], amp[2]));
      settle();
    end

    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
